// File: hw/rtl/lsm_pkg.sv
package lsm_pkg;

  localparam int MaxBins   = 4096;
  localparam int BinAw     = 12;
  localparam int RangeBits = 16;
  localparam int AngleBits = 16;
  localparam int CordicW   = 48;
  localparam int CordicZW  = 34;
  localparam int Iters     = 24;

  localparam logic [RangeBits-1:0] NoReturn = '1;
  localparam logic [29:0]          GainQ30  = 30'd652032874;

  typedef enum logic [2:0] {
    StStored     = 3'd0,
    StInvalid    = 3'd1,
    StInBody     = 3'd2,
    StOutOfRange = 3'd3,
    StNotCloser  = 3'd4,
    StReadData   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    RegLeftBox    = 3'd0,
    RegRightBox   = 3'd1,
    RegLeftPose   = 3'd2,
    RegRightPose  = 3'd3,
    RegStartAngle = 3'd4,
    RegAngleStep  = 3'd5,
    RegRangeLimit = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic        action;
    logic        sensor_side;
    logic [11:0] ray_index;
    logic [15:0] range_mm;
    logic        range_valid;
    logic [15:0] ray_intensity;
    logic        has_intensity;
    logic [11:0] bin_select;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] bin_touched;
    logic [15:0] bin_range;
    logic [15:0] bin_intensity;
  } out_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// File: hw/rtl/lidar_scan_merge_with_body_mask_top.sv
// A ray request passes through two 24-step CORDIC passes on one shared unit and a
// 17-step bin divider between acceptance and result.
// A read-and-clear request passes through a read state and an update state. One request is in work at a time, so a
// new request is taken only once the previous result has gone to the output register.
// After reset the bin memory is cleared, one bin per cycle, before
// the first request is accepted; configuration writes are taken throughout.
module lidar_scan_merge_with_body_mask_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [5:0]     paddr,
  input  logic [63:0]    pwdata,
  output logic [63:0]    prdata,
  output logic           pready,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lsm_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lsm_pkg::out_t  out_data_o
);

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_THETA  = 14'b00000000000100,
    S_ROT    = 14'b00000000001000,
    S_ROTFIN = 14'b00000000010000,
    S_BOX    = 14'b00000000100000,
    S_VEC    = 14'b00000001000000,
    S_RNG    = 14'b00000010000000,
    S_RCHK   = 14'b00000100000000,
    S_DIV    = 14'b00001000000000,
    S_BCHK   = 14'b00010000000000,
    S_RD     = 14'b00100000000000,
    S_UPD    = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } state_e;

  // Configuration registers.
  logic [63:0] lbox_q, rbox_q;
  logic [47:0] lpose_q, rpose_q;
  logic [31:0] starts_q, limits_q;
  logic [15:0] astep_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lbox_q   <= '0;
      rbox_q   <= '0;
      lpose_q  <= '0;
      rpose_q  <= '0;
      starts_q <= '0;
      astep_q  <= 16'd182;
      limits_q <= 32'hFFFF0000;
    end else if (cfg_wr) begin
      case (lsm_pkg::reg_idx_e'(paddr[5:3]))
        lsm_pkg::RegLeftBox:    lbox_q   <= pwdata;
        lsm_pkg::RegRightBox:   rbox_q   <= pwdata;
        lsm_pkg::RegLeftPose:   lpose_q  <= pwdata[47:0];
        lsm_pkg::RegRightPose:  rpose_q  <= pwdata[47:0];
        lsm_pkg::RegStartAngle: starts_q <= pwdata[31:0];
        lsm_pkg::RegAngleStep:  astep_q  <= pwdata[15:0];
        lsm_pkg::RegRangeLimit: limits_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lsm_pkg::reg_idx_e'(paddr[5:3]))
      lsm_pkg::RegLeftBox:    prdata = lbox_q;
      lsm_pkg::RegRightBox:   prdata = rbox_q;
      lsm_pkg::RegLeftPose:   prdata = {16'h0, lpose_q};
      lsm_pkg::RegRightPose:  prdata = {16'h0, rpose_q};
      lsm_pkg::RegStartAngle: prdata = {32'h0, starts_q};
      lsm_pkg::RegAngleStep:  prdata = {48'h0, astep_q};
      lsm_pkg::RegRangeLimit: prdata = {32'h0, limits_q};
      default:                prdata = '0;
    endcase
  end

  // Datapath registers.
  state_e                state_q, state_d;
  logic [11:0]           clr_q, clr_d;
  lsm_pkg::in_t          item_q, item_d;
  logic [1:0]            quad_q, quad_d;
  logic signed [17:0]    px_q, px_d, py_q, py_d;
  logic [21:0]           orng_q, orng_d;
  logic [31:0]           ang_q, ang_d;
  logic [16:0]           divn_q, divn_d;
  logic [15:0]           rem_q, rem_d;
  logic [4:0]            dcnt_q, dcnt_d;
  logic [11:0]           bin_q, bin_d;
  lsm_pkg::status_e      drop_q, drop_d;
  logic                  out_valid_q, out_valid_d;
  lsm_pkg::out_t         out_q, out_d;

  // Memory and CORDIC hookup.
  logic                  ram_we, ram_re;
  logic [11:0]           ram_waddr;
  logic [31:0]           ram_wdata, ram_rdata;
  lsm_pkg::cordic_ctl_t  cctl;
  logic signed [47:0]    cx0, cy0, cx, cy;
  logic signed [33:0]    cz0, cz;
  logic                  cdone;

  // Derived values.
  logic [15:0]        step_eff, rmin, rmax, start16, theta, tq;
  logic [63:0]        box;
  logic [47:0]        pose;
  logic [31:0]        zrot;
  logic [45:0]        xr;
  logic signed [47:0] rx, ry, rxs, rys;
  logic signed [18:0] ox, oy, ax, ay, bminx, bmaxx, bminy, bmaxy, pxe, pye;
  logic               in_box, at_origin, neg, in_lim, out_free;
  logic [57:0]        rprod, rrnd;
  logic [31:0]        u;
  logic [32:0]        nsum, bprod;
  logic [16:0]        rem_sh, bin_full;
  logic               ge;
  logic [15:0]        st_r, st_i, new_r, new_i;
  logic               closer;

  always_comb begin
    step_eff = (astep_q == 16'd0) ? 16'd1 : astep_q;
    rmin     = limits_q[15:0];
    rmax     = limits_q[31:16];
    box      = item_q.sensor_side ? rbox_q : lbox_q;
    pose     = item_q.sensor_side ? rpose_q : lpose_q;
    start16  = item_q.sensor_side ? starts_q[31:16] : starts_q[15:0];
    in_lim   = !(item_q.range_mm < rmin || item_q.range_mm > rmax);

    theta = start16 + 16'(item_q.ray_index * step_eff) + pose[47:32];
    tq    = theta + 16'h2000;
    zrot  = {theta, 16'h0} - {tq[15:14], 30'h0};
    xr    = {30'h0, item_q.range_mm} * {16'h0, lsm_pkg::GainQ30};

    case (quad_q)
      2'd1:    begin rx = -cy; ry = cx;  end
      2'd2:    begin rx = -cx; ry = -cy; end
      2'd3:    begin rx = cy;  ry = -cx; end
      default: begin rx = cx;  ry = cy;  end
    endcase
    rxs = rx + 48'sh20000000;
    rys = ry + 48'sh20000000;

    bminx  = 19'(signed'(box[15:0]));
    bmaxx  = 19'(signed'(box[31:16]));
    bminy  = 19'(signed'(box[47:32]));
    bmaxy  = 19'(signed'(box[63:48]));
    pxe    = 19'(px_q);
    pye    = 19'(py_q);
    in_box = (pxe >= bminx) && (pxe <= bmaxx) && (pye >= bminy) && (pye <= bmaxy);

    ox        = pxe + 19'(signed'(pose[15:0]));
    oy        = pye + 19'(signed'(pose[31:16]));
    at_origin = (ox == 19'sd0) && (oy == 19'sd0);
    neg       = ox[18];
    ax        = neg ? -ox : ox;
    ay        = neg ? -oy : oy;

    // The vectoring magnitude is floored to Q6 before the gain multiply.
    rprod = {30'h0, cx[41:14]} * {28'h0, lsm_pkg::GainQ30};
    rrnd  = rprod + 58'h800000000;

    u    = ang_q + 32'h80000000;
    nsum = {1'b0, u} + {2'b00, step_eff, 15'h0};

    rem_sh = {rem_q, divn_q[16]};
    ge     = rem_sh >= {1'b0, step_eff};

    // A bin at or past ceil(turn/step) wraps to zero: bin*step >= one turn.
    bprod    = {16'h0, divn_q} * {17'h0, step_eff};
    bin_full = (bprod >= 33'h10000) ? 17'd0 : divn_q;

    st_r   = ram_rdata[31:16];
    st_i   = ram_rdata[15:0];
    closer = orng_q < {6'h0, st_r};
    new_r  = closer ? orng_q[15:0] : st_r;
    new_i  = (closer && item_q.has_intensity) ? item_q.ray_intensity : st_i;

    out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    item_d      = item_q;
    quad_d      = quad_q;
    px_d        = px_q;
    py_d        = py_q;
    orng_d      = orng_q;
    ang_d       = ang_q;
    divn_d      = divn_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    bin_d       = bin_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = bin_q;
    ram_wdata   = {lsm_pkg::NoReturn, 16'h0};
    cctl        = '0;
    cx0         = 48'(xr);
    cy0         = '0;
    cz0         = 34'(signed'(zrot));

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 12'd1;
        if (clr_q == 12'(lsm_pkg::MaxBins - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          bin_d   = in_data_i.bin_select;
          state_d = in_data_i.action ? S_RD : S_THETA;
        end
      end
      S_THETA: begin
        if (!item_q.range_valid) begin
          drop_d  = lsm_pkg::StInvalid;
          state_d = S_EMIT;
        end else if (!in_lim) begin
          drop_d  = lsm_pkg::StOutOfRange;
          state_d = S_EMIT;
        end else begin
          cctl.start = 1'b1;
          quad_d     = tq[15:14];
          state_d    = S_ROT;
        end
      end
      S_ROT: begin
        if (cdone) begin
          state_d = S_ROTFIN;
        end
      end
      S_ROTFIN: begin
        px_d    = rxs[47:30];
        py_d    = rys[47:30];
        state_d = S_BOX;
      end
      S_BOX: begin
        cx0 = {{9{ax[18]}}, ax, 20'h0};
        cy0 = {{9{ay[18]}}, ay, 20'h0};
        cz0 = neg ? 34'sh080000000 : 34'sh0;
        if (in_box) begin
          drop_d  = lsm_pkg::StInBody;
          state_d = S_EMIT;
        end else if (at_origin) begin
          orng_d  = '0;
          ang_d   = '0;
          state_d = S_RCHK;
        end else begin
          cctl.start     = 1'b1;
          cctl.vectoring = 1'b1;
          state_d        = S_VEC;
        end
      end
      S_VEC: begin
        if (cdone) begin
          state_d = S_RNG;
        end
      end
      S_RNG: begin
        orng_d  = rrnd[57:36];
        ang_d   = cz[31:0];
        state_d = S_RCHK;
      end
      S_RCHK: begin
        if (orng_q < {6'h0, rmin} || orng_q > {6'h0, rmax}) begin
          drop_d  = lsm_pkg::StOutOfRange;
          state_d = S_EMIT;
        end else begin
          divn_d  = nsum[32:16];
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = ge ? 16'(rem_sh - {1'b0, step_eff}) : rem_sh[15:0];
        divn_d = {divn_q[15:0], ge};
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd16) begin
          state_d = S_BCHK;
        end
      end
      S_BCHK: begin
        if (bin_full >= 17'(lsm_pkg::MaxBins)) begin
          drop_d  = lsm_pkg::StOutOfRange;
          state_d = S_EMIT;
        end else begin
          bin_d   = bin_full[11:0];
          state_d = S_RD;
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.bin_touched = bin_q;
          if (item_q.action) begin
            ram_we              = 1'b1;
            out_d.status        = lsm_pkg::StReadData;
            out_d.bin_range     = st_r;
            out_d.bin_intensity = st_i;
          end else begin
            ram_we              = closer;
            ram_wdata           = {new_r, new_i};
            out_d.status        = closer ? lsm_pkg::StStored : lsm_pkg::StNotCloser;
            out_d.bin_range     = new_r;
            out_d.bin_intensity = new_i;
          end
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: drop_q, bin_touched: '0, bin_range: '0,
                          bin_intensity: '0};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    quad_q <= quad_d;
    px_q   <= px_d;
    py_q   <= py_d;
    orng_q <= orng_d;
    ang_q  <= ang_d;
    divn_q <= divn_d;
    rem_q  <= rem_d;
    bin_q  <= bin_d;
    drop_q <= drop_d;
    out_q  <= out_d;
  end

  lsm_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cctl),
    .x0_i   (cx0),
    .y0_i   (cy0),
    .z0_i   (cz0),
    .x_o    (cx),
    .y_o    (cy),
    .z_o    (cz),
    .done_o (cdone)
  );

  lsm_ram #(
    .Width (32),
    .Depth (lsm_pkg::MaxBins)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (bin_q),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/lsm_ram.sv
module lsm_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lsm_cordic.sv
module lsm_cordic (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lsm_pkg::cordic_ctl_t                  ctl_i,
  input  logic signed [lsm_pkg::CordicW-1:0]    x0_i,
  input  logic signed [lsm_pkg::CordicW-1:0]    y0_i,
  input  logic signed [lsm_pkg::CordicZW-1:0]   z0_i,
  output logic signed [lsm_pkg::CordicW-1:0]    x_o,
  output logic signed [lsm_pkg::CordicW-1:0]    y_o,
  output logic signed [lsm_pkg::CordicZW-1:0]   z_o,
  output logic                                  done_o
);

  logic                                busy_q, done_q, vec_q;
  logic [4:0]                          iter_q;
  logic signed [lsm_pkg::CordicW-1:0]  x_q, y_q, dx, dy;
  logic signed [lsm_pkg::CordicZW-1:0] z_q, at;
  logic                                sigma;

  // Rotation drives z toward zero, vectoring drives y toward zero.
  always_comb begin
    dx    = y_q >>> iter_q;
    dy    = x_q >>> iter_q;
    at    = lsm_pkg::CordicZW'(lsm_pkg::atan_turn(iter_q));
    sigma = vec_q ? y_q[lsm_pkg::CordicW-1] : !z_q[lsm_pkg::CordicZW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 5'd1;
        if (iter_q == 5'(lsm_pkg::Iters - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      x_q   <= x0_i;
      y_q   <= y0_i;
      z_q   <= z0_i;
      vec_q <= ctl_i.vectoring;
    end else if (busy_q) begin
      if (sigma) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

// File: sim/lsm_checker.sv
module lsm_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [5:0]     paddr,
  input  logic [63:0]    pwdata,
  input  logic           pready,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  lsm_pkg::in_t   in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  lsm_pkg::out_t  out_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  import lsm_pkg::*;

  logic [63:0] box_q [2];
  logic [47:0] pose_q [2];
  logic [31:0] start_q;
  logic [15:0] step_q;
  logic [31:0] limits_q;
  logic [15:0] range_store [MaxBins];
  logic [15:0] inten_store [MaxBins];
  out_t        bin_results_q [$];

  function automatic longint sx16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  // Rotation CORDIC on a gain-prescaled Q30 range, rounded to whole mm.
  function automatic void ray_point(input longint r, input logic [31:0] phi,
                                    output longint px, output longint py);
    logic [1:0]  q;
    logic [31:0] zr;
    longint      x, y, z, dx, dy, t;
    q  = 2'((phi + 32'h2000_0000) >> 30);
    zr = phi - {q, 30'b0};
    z  = longint'(signed'(zr));
    x  = r * longint'(GainQ30);
    y  = 0;
    for (int i = 0; i < Iters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(5'(i)));
      end
    end
    case (q)
      2'd1: begin t = x; x = -y; y = t; end
      2'd2: begin x = -x; y = -y; end
      2'd3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    px = (x + (64'sd1 <<< 29)) >>> 30;
    py = (y + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Vectoring CORDIC on Q20 mm back to range and angle.
  function automatic void point_polar(input longint ox, input longint oy,
                                      output longint rng, output logic [31:0] ang);
    longint      x, y, nx;
    logic [63:0] prod;
    x   = ox <<< 20;
    y   = oy <<< 20;
    ang = 32'h0;
    if (ox == 0 && oy == 0) begin
      rng = 0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; ang = 32'h8000_0000;
    end
    for (int i = 0; i < Iters; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); ang += atan_turn(5'(i));
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); ang -= atan_turn(5'(i));
      end
      x = nx;
    end
    prod = 64'(x >>> 14) * 64'(GainQ30) + (64'd1 << 35);
    rng  = longint'(prod >> 36);
  endfunction

  function automatic out_t merge_request(in_t req);
    out_t        res;
    logic [15:0] rmin, rmax, stp, start;
    logic [63:0] box;
    logic [47:0] pose;
    logic [15:0] theta;
    logic [31:0] ang, u;
    longint      px, py, orng, bin, nbins, d;
    res   = '0;
    rmin  = limits_q[15:0];
    rmax  = limits_q[31:16];
    stp   = (step_q == 16'd0) ? 16'd1 : step_q;
    box   = box_q[req.sensor_side];
    pose  = pose_q[req.sensor_side];
    start = req.sensor_side ? start_q[31:16] : start_q[15:0];
    if (req.action) begin
      res.status        = StReadData;
      res.bin_touched   = req.bin_select;
      res.bin_range     = range_store[req.bin_select];
      res.bin_intensity = inten_store[req.bin_select];
      range_store[req.bin_select] = NoReturn;
      inten_store[req.bin_select] = '0;
      return res;
    end
    if (!req.range_valid) begin
      res.status = StInvalid;
      return res;
    end
    if (req.range_mm < rmin || req.range_mm > rmax) begin
      res.status = StOutOfRange;
      return res;
    end
    theta = start + 16'(req.ray_index * stp) + pose[47:32];
    ray_point(longint'(req.range_mm), {theta, 16'h0}, px, py);
    if (px >= sx16(box[15:0]) && px <= sx16(box[31:16]) &&
        py >= sx16(box[47:32]) && py <= sx16(box[63:48])) begin
      res.status = StInBody;
      return res;
    end
    point_polar(px + sx16(pose[15:0]), py + sx16(pose[31:16]), orng, ang);
    if (orng < longint'(rmin) || orng > longint'(rmax)) begin
      res.status = StOutOfRange;
      return res;
    end
    u     = ang + 32'h8000_0000;
    d     = longint'(stp) <<< 16;
    bin   = (longint'(u) + d / 2) / d;
    nbins = (65536 + longint'(stp) - 1) / longint'(stp);
    if (bin >= nbins) bin = 0;
    if (bin >= MaxBins) begin
      res.status = StOutOfRange;
      return res;
    end
    if (orng < longint'(range_store[bin])) begin
      range_store[bin] = 16'(orng);
      if (req.has_intensity) inten_store[bin] = req.ray_intensity;
      res.status = StStored;
    end else begin
      res.status = StNotCloser;
    end
    res.bin_touched   = 12'(bin);
    res.bin_range     = range_store[bin];
    res.bin_intensity = inten_store[bin];
    return res;
  endfunction

  assign pending_o = bin_results_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      box_q[0]  <= '0; box_q[1] <= '0;
      pose_q[0] <= '0; pose_q[1] <= '0;
      start_q   <= '0;
      step_q    <= 16'd182;
      limits_q  <= 32'hFFFF_0000;
      for (int i = 0; i < MaxBins; i++) begin
        range_store[i] = NoReturn;
        inten_store[i] = '0;
      end
      bin_results_q.delete();
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[5:3]))
          RegLeftBox:    box_q[0]  <= pwdata;
          RegRightBox:   box_q[1]  <= pwdata;
          RegLeftPose:   pose_q[0] <= pwdata[47:0];
          RegRightPose:  pose_q[1] <= pwdata[47:0];
          RegStartAngle: start_q   <= pwdata[31:0];
          RegAngleStep:  step_q    <= pwdata[15:0];
          RegRangeLimit: limits_q  <= pwdata[31:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        bin_results_q = {bin_results_q, merge_request(in_data_i)};
      end
      if (out_valid_i && out_ready_i) begin
        if (bin_results_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = bin_results_q.pop_front();
          if (out_data_i.status !== want.status ||
              out_data_i.bin_touched !== want.bin_touched ||
              out_data_i.bin_range !== want.bin_range ||
              out_data_i.bin_intensity !== want.bin_intensity) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: sim/testbench.sv
module testbench;
  import lsm_pkg::*;

  localparam int StallLimit = 20000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]    paddr = '0;
  logic [63:0]   pwdata = '0;
  logic [63:0]   prdata;
  logic          pready;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  in_t           in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  out_t          out_data_o;
  int            fail_count, pending;
  int            send_idle_pct = 0, recv_idle_pct = 0;
  bit            hold_req = 1'b0;
  logic [15:0]   cur_step = 16'd182;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lidar_scan_merge_with_body_mask_top dut (.*);

  lsm_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver side; a long hold-off lets requests pile up behind a full block.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    int quiet;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) quiet = 0;
    else quiet++;
    if (quiet >= StallLimit) begin
      $display("lidar_scan_merge_with_body_mask_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 6'(idx * 8); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == RegAngleStep) cur_step = value[15:0];
  endtask

  task automatic send_request(in_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic in_t ray(logic side, logic [11:0] idx, logic [15:0] rng,
                              logic [15:0] inten, logic has_int);
    in_t r;
    r = '0;
    r.sensor_side   = side;
    r.ray_index     = idx;
    r.range_mm      = rng;
    r.range_valid   = 1'b1;
    r.ray_intensity = inten;
    r.has_intensity = has_int;
    r.bin_select    = 12'($urandom());
    return r;
  endfunction

  function automatic in_t bin_read(logic [11:0] sel);
    in_t r;
    r = in_t'(60'({$urandom(), $urandom()}));
    r.action     = 1'b1;
    r.bin_select = sel;
    return r;
  endfunction

  function automatic in_t random_request();
    in_t r;
    int  nbins;
    nbins = 65536 / cur_step;
    if ($urandom_range(99) < 25) return bin_read(($urandom_range(9) == 0) ?
        12'($urandom()) : 12'($urandom_range(nbins)));
    r = ray(1'($urandom_range(1)), 12'($urandom()),
            ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(3000)),
            16'($urandom()), $urandom_range(3) != 0);
    if ($urandom_range(19) == 0) r.range_valid = 1'b0;
    return r;
  endfunction

  task automatic quiesce();
    in_valid_i <= 1'b0;
    // The wait on the clock lets the checker record the last accepted request.
    @(posedge clk_i);
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic configure(int phase);
    case (phase)
      0: begin
        write_reg(RegLeftBox,  {16'sd100, -16'sd100, 16'sd100, -16'sd100});
        write_reg(RegRightBox, {16'sd50, -16'sd50, 16'sd80, -16'sd80});
        write_reg(RegLeftPose,  {16'h0000, 16'sd0, 16'sd0});
        write_reg(RegRightPose, {16'h2000, -16'sd200, 16'sd300});
        write_reg(RegStartAngle, {16'h4000, 16'h0000});
        write_reg(RegAngleStep, 64'd182);
        write_reg(RegRangeLimit, {16'd60000, 16'd10});
      end
      1: begin
        write_reg(RegLeftBox,  {16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000});
        write_reg(RegRightBox, 64'h0);
        write_reg(RegLeftPose,  {16'h8000, 16'h7FFF, 16'h8000});
        write_reg(RegRightPose, {16'hFFFF, 16'h8000, 16'h7FFF});
        write_reg(RegStartAngle, 64'hFFFF_8000);
        write_reg(RegAngleStep, 64'd16);
        write_reg(RegRangeLimit, {16'd65535, 16'd0});
      end
      2: begin
        write_reg(RegLeftBox, {$urandom(), $urandom()});
        write_reg(RegRightBox, {16'sd20, -16'sd20, 16'sd20, -16'sd20});
        write_reg(RegLeftPose, {$urandom(), $urandom()});
        write_reg(RegStartAngle, $urandom());
        write_reg(RegAngleStep, 64'd65535);
        write_reg(RegRangeLimit, {16'd40000, 16'd100});
      end
      default: begin
        write_reg(RegLeftPose, {16'($urandom()), 16'($urandom_range(400)), 16'($urandom())});
        write_reg(RegRightPose, {16'($urandom()), 16'($urandom()), 16'($urandom())});
        write_reg(RegAngleStep, 64'($urandom_range(16, 2000)));
        write_reg(RegRangeLimit, {16'($urandom_range(2000, 65535)), 16'($urandom_range(50))});
      end
    endcase
  endtask

  initial begin
    in_t r;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    configure(0);
    send_idle_pct = 27;
    recv_idle_pct = 83;

    // Empty bin, invalid return, range limits at both ends, body box, no intensity.
    send_request(bin_read(12'd0));
    r = ray(0, 12'd5, 16'd500, 16'hFFFF, 1); r.range_valid = 1'b0; send_request(r);
    send_request(ray(0, 12'd0, 16'd0, 16'd1, 1));
    send_request(ray(0, 12'd0, 16'd5, 16'd1, 1));
    send_request(ray(0, 12'd0, 16'd65535, 16'd1, 1));
    send_request(ray(0, 12'd10, 16'd50, 16'd7, 1));
    send_request(ray(0, 12'd10, 16'd1000, 16'hABCD, 1));
    send_request(ray(0, 12'd10, 16'd1000, 16'h1234, 1));
    send_request(ray(0, 12'd10, 16'd900, 16'h5555, 0));
    send_request(ray(0, 12'd10, 16'd60000, 16'h1, 1));
    // Rays near a half turn fall into the last bin and into bin one.
    send_request(ray(0, 12'd180, 16'd2000, 16'h0F0F, 1));
    send_request(ray(0, 12'd181, 16'd2000, 16'hF0F0, 1));
    send_request(ray(1, 12'd4095, 16'd3000, 16'h8001, 1));
    send_request(ray(1, 12'd100, 16'd10, 16'h7FFE, 1));
    send_request(bin_read(12'd0));
    send_request(bin_read(12'd4095));
    send_request(bin_read(12'hAAA));
    send_request(bin_read(12'h555));

    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        quiesce();
        configure(phase);
      end
      case (phase)
        1: begin send_idle_pct = 83; recv_idle_pct = 27; end
        2: begin send_idle_pct = 0;  recv_idle_pct = 0; hold_req = 1'b1; end
        default: ;
      endcase
      if (phase == 1) begin
        // A one-mm ray that lands inside the left body box.
        send_request(ray(0, 12'd0, 16'd1, 16'd3, 1));
      end
      for (int n = 0; n < 250; n++) send_request(random_request());
    end

    quiesce();
    if (fail_count == 0) begin
      $display("lidar_scan_merge_with_body_mask_top verification clean");
    end else begin
      $display("lidar_scan_merge_with_body_mask_top verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lsm_pkg.sv
hw/rtl/lsm_ram.sv
hw/rtl/lsm_cordic.sv
hw/rtl/lidar_scan_merge_with_body_mask_top.sv
sim/lsm_checker.sv
sim/testbench.sv
